/* src/rbfi_pkg.sv */
// ----------------------------------------------------------------------------
// rbfi_pkg: shared types for the unit box face intersection block
// Job record written by the front end, the side record carried next to the
// dividers, and the candidate record used by the nearest-face selection.
// ----------------------------------------------------------------------------
package rbfi_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned MIN_DIST_W = 17;
  localparam int unsigned S_DATA_W  = 192;
  localparam int unsigned M_DATA_W  = 40;

  localparam logic [2:0] FACE_NEG_X = 3'd0;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [2:0][31:0] dmag;
    logic [5:0][31:0] nmag;
    logic [5:0]       neg;
    logic [2:0]       dzero;
  } ray_job_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [5:0]       neg;
    logic [2:0]       dzero;
  } side_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] t;
    logic [2:0]  face;
  } cand_t;

  // Earlier candidate a wins if valid, unless b is valid and strictly nearer; else b.
  function automatic cand_t pick_near(cand_t a, cand_t b);
    if (a.ok && (!b.ok || ($signed(a.t) <= $signed(b.t)))) begin
      return a;
    end
    return b;
  endfunction

endpackage

/* src/rbfi_front.sv */
// ----------------------------------------------------------------------------
// rbfi_front: ray classification
// Splits a ray beat into per-face numerator magnitudes, quotient signs and
// per-axis divisor magnitudes and zero flags.
// ----------------------------------------------------------------------------
module rbfi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic [rbfi_pkg::S_DATA_W-1:0] tdata,
  output rbfi_pkg::ray_job_t            job
);
  import rbfi_pkg::*;

  localparam logic signed [32:0] HALF = 33'sd1 <<< (FRAC_BITS - 1);

  always_comb begin
    logic signed [32:0] plane;
    logic signed [32:0] diff;
    job = '0;
    for (int k = 0; k < 3; k++) begin
      job.org[k]   = tdata[32*k +: 32];
      job.dir[k]   = tdata[96 + 32*k +: 32];
      job.dmag[k]  = job.dir[k][31] ? (32'd0 - job.dir[k]) : job.dir[k];
      job.dzero[k] = (job.dir[k] == 32'd0);
    end
    for (int f = 0; f < 6; f++) begin
      plane = (f % 2 == 1) ? HALF : -HALF;
      diff  = plane - $signed({job.org[f/2][31], job.org[f/2]});
      job.nmag[f] = diff[32] ? 32'(-diff) : diff[31:0];
      job.neg[f]  = diff[32] ^ job.dir[f/2][31];
    end
  end

endmodule

/* src/rbfi_fifo.sv */
// ----------------------------------------------------------------------------
// rbfi_fifo: job queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rbfi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty && pop |-> push) else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full && push |-> pop) else $error("push into full queue");

endmodule

/* src/rbfi_div.sv */
// ----------------------------------------------------------------------------
// rbfi_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module rbfi_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW+NW-1:0] w   [NW];
  logic [DW-1:0]    dv  [NW];

  function automatic logic [DW+NW-1:0] step(logic [DW+NW-1:0] wi, logic [DW-1:0] d);
    logic [DW:0]      trial;
    logic [DW+NW-1:0] wo;
    trial = wi[DW+NW-1:NW-1] - {1'b0, d};
    wo    = wi << 1;
    if (!trial[DW]) begin
      wo[DW+NW-1:NW] = trial[DW-1:0];
      wo[0]          = 1'b1;
    end
    return wo;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      w[0]  <= step({{DW{1'b0}}, num}, den);
      dv[0] <= den;
      for (int i = 1; i < NW; i++) begin
        w[i]  <= step(w[i-1], dv[i-1]);
        dv[i] <= dv[i-1];
      end
    end
  end

  assign quo = w[NW-1][NW-1:0];

endmodule

/* src/rbfi_back.sv */
// ----------------------------------------------------------------------------
// rbfi_back: face evaluation pipeline
// Divides, saturates, forms hit points, tests faces and picks the nearest.
// ----------------------------------------------------------------------------
module rbfi_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rbfi_pkg::MIN_DIST_W-1:0]   min_distance,
  input  logic                              job_valid,
  input  rbfi_pkg::ray_job_t                job,
  output logic                              job_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rbfi_pkg::M_DATA_W-1:0]     m_tdata,
  output logic [0:0]                        m_tuser
);
  import rbfi_pkg::*;

  localparam int QW = 32 + FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [31:0] MISS_DIST = 32'(-(64'sd1 <<< FRAC_BITS));

  logic adv;
  assign adv     = !m_tvalid || m_tready;
  assign job_pop = adv && job_valid;

  // Divider array and matching side line.
  logic [QW-1:0] quo [6];
  side_t         side [QW];
  logic [QW-1:0] vld;

  for (genvar f = 0; f < 6; f++) begin : g_div
    rbfi_div #(.NW(QW), .DW(32)) u_div (
      .clk (clk),
      .en  (adv),
      .num ({job.nmag[f], {FRAC_BITS{1'b0}}}),
      .den (job.dmag[f/2]),
      .quo (quo[f])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0].org   <= job.org;
      side[0].dir   <= job.dir;
      side[0].neg   <= job.neg;
      side[0].dzero <= job.dzero;
      for (int i = 1; i < QW; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // Saturation stage.
  logic [5:0][31:0] t_s;
  side_t            side_s;
  logic             vld_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_s <= side[QW-1];
      for (int f = 0; f < 6; f++) begin
        if (side[QW-1].neg[f]) begin
          t_s[f] <= (quo[f][QW-1:31] != '0) ? 32'h8000_0000 : 32'd0 - quo[f][31:0];
        end else begin
          t_s[f] <= (quo[f][QW-1:31] != '0) ? 32'h7FFF_FFFF : quo[f][31:0];
        end
      end
    end
  end

  // Product stage.
  logic signed [63:0] prod [6][2];
  logic [5:0][31:0]   t_p;
  logic [5:0]         gt_p;
  side_t              side_p;
  logic               vld_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_p    <= t_s;
      side_p <= side_s;
      for (int f = 0; f < 6; f++) begin
        prod[f][0] <= $signed(t_s[f]) * $signed(side_s.dir[((f/2)+1)%3]);
        prod[f][1] <= $signed(t_s[f]) * $signed(side_s.dir[((f/2)+2)%3]);
        gt_p[f]    <= $signed({t_s[f][31], t_s[f]}) > $signed({16'd0, min_distance});
      end
    end
  end

  // Containment stage.
  cand_t cand_c [6];
  logic  vld_c;

  always_ff @(posedge clk) begin
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    if (adv) begin
      for (int f = 0; f < 6; f++) begin
        c1 = 64'($signed(side_p.org[((f/2)+1)%3])) + (prod[f][0] >>> FRAC_BITS);
        c2 = 64'($signed(side_p.org[((f/2)+2)%3])) + (prod[f][1] >>> FRAC_BITS);
        cand_c[f].ok   <= !side_p.dzero[f/2] && gt_p[f] && (c1 > -HALF) && (c1 < HALF)
                          && (c2 > -HALF) && (c2 < HALF);
        cand_c[f].t    <= t_p[f];
        cand_c[f].face <= 3'(f);
      end
    end
  end

  // Pairwise selection stage.
  cand_t pair_a [3];
  logic  vld_a;
  cand_t best;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++) begin
        pair_a[p] <= pick_near(cand_c[2*p], cand_c[2*p+1]);
      end
    end
  end

  assign best = pick_near(pick_near(pair_a[0], pair_a[1]), pair_a[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= best.ok;
      m_tdata <= best.ok ? {5'd0, best.face, best.t} : {5'd0, FACE_NEG_X, MISS_DIST};
    end
  end

  // Valid line through all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      vld_s    <= 1'b0;
      vld_p    <= 1'b0;
      vld_c    <= 1'b0;
      vld_a    <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[QW-2:0], job_valid};
      vld_s    <= vld[QW-1];
      vld_p    <= vld_s;
      vld_c    <= vld_p;
      vld_a    <= vld_c;
      m_tvalid <= vld_a;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[34:32] == FACE_NEG_X && m_tdata[31:0] == MISS_DIST)
    else $error("miss result carries wrong fields");
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[34:32] <= 3'd5)
    else $error("face index out of range");
  a_hit_positive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[31])
    else $error("hit with negative distance");

endmodule

/* src/ray_unit_box_face_intersect.sv */
// ----------------------------------------------------------------------------
// ray_unit_box_face_intersect: ray test against the unit box
// Streams rays in canonical box space and returns nearest-face hit results.
// ----------------------------------------------------------------------------
// One ray beat in, one result beat out, at a sustained rate of one ray per
// clock while the result side does not stall. Each accepted ray is written
// into the job queue and then passes through the back end: the
// bit-per-stage dividers, one for each face, followed by saturation,
// hit-point multiply, containment test and two selection stages. A stall on
// the result side freezes the back end; the queue then keeps taking rays
// until it is full.
// The input beat carries origin x, y, z and direction x, y, z, each signed
// Q16.16 (Q.FRAC_BITS). The result beat carries the distance and face in
// tdata and the hit flag in tuser; a miss returns distance -1.0 and face 0.
// Self-hit threshold min_distance resets to 66; the user must write it only
// through min_distance_we while the block is idle; no logic enforces it.
module ray_unit_box_face_intersect #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            min_distance_we,
  input  logic [rbfi_pkg::MIN_DIST_W-1:0] min_distance_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [rbfi_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit_distance [31:0], face_index [34:32], zero fill [39:35]
  output logic [rbfi_pkg::M_DATA_W-1:0]   m_tdata,
  // hit [0]
  output logic [0:0]                      m_tuser
);
  import rbfi_pkg::*;

  // Threshold register; a hit must be strictly farther than this.
  logic [MIN_DIST_W-1:0] min_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_W'(66);
    end else if (min_distance_we) begin
      min_distance <= min_distance_wdata;
    end
  end

  // Front end: classify the incoming ray into per-face division jobs.
  ray_job_t job_in;
  ray_job_t job_head;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     q_push;

  rbfi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .tdata (s_tdata),
    .job   (job_in)
  );

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Queue decouples the front end from the stall of the back end.
  rbfi_fifo #(.WIDTH($bits(ray_job_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (job_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (job_head),
    .empty (q_empty)
  );

  // Back end: divide, test faces, select the nearest, hold the result beat.
  rbfi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .min_distance (min_distance),
    .job_valid    (!q_empty),
    .job          (job_head),
    .job_pop      (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

endmodule
